// File: sv/csi2rp_pkg.sv
// Shared types, constants and the group packing function of the CSI-2 RAW pixel packer.
`default_nettype none

package csi2rp_pkg;

  localparam int unsigned GroupMax   = 8;
  localparam int unsigned MaxBytes   = 7;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned PixW       = 24;
  localparam int unsigned StoreW     = 20;
  localparam int unsigned FmtW       = 4;
  localparam int unsigned PosW       = $clog2(GroupMax);
  localparam int unsigned LenW       = $clog2(GroupMax + 1);
  localparam int unsigned CntW       = $clog2(MaxBytes + 1);

  typedef enum logic [FmtW-1:0] {
    FmtRaw6   = 4'd0,
    FmtRaw7   = 4'd1,
    FmtRaw8   = 4'd2,
    FmtRaw10  = 4'd3,
    FmtRaw12  = 4'd4,
    FmtRaw14  = 4'd5,
    FmtRaw16  = 4'd6,
    FmtRaw20  = 4'd7,
    FmtRgb888 = 4'd8
  } fmt_e;

  typedef struct packed {
    logic [PixW-1:0] pixel;
    logic            line_end;
  } pix_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       line_done;
  } byte_rsp_t;

  // One finished group: its payload bytes in send order, how many, and the line end flag.
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [CntW-1:0]          count;
    logic                     line_end;
  } group_t;

  typedef logic [GroupMax-1:0][PixW-1:0] px_vec_t;

  // Pixels per group; zero for codes that name no format.
  function automatic logic [LenW-1:0] group_len(input logic [FmtW-1:0] fmt);
    logic [LenW-1:0] len;
    case (fmt)
      FmtRaw6:   len = LenW'(4);
      FmtRaw7:   len = LenW'(8);
      FmtRaw8:   len = LenW'(1);
      FmtRaw10:  len = LenW'(4);
      FmtRaw12:  len = LenW'(2);
      FmtRaw14:  len = LenW'(4);
      FmtRaw16:  len = LenW'(1);
      FmtRaw20:  len = LenW'(2);
      FmtRgb888: len = LenW'(1);
      default:   len = '0;
    endcase
    return len;
  endfunction

  function automatic group_t pack_group(input logic [FmtW-1:0] fmt, input px_vec_t p,
                                        input logic line_end);
    group_t g;
    g          = '0;
    g.line_end = line_end;
    case (fmt)
      FmtRaw6: begin
        g.bytes[0] = {p[1][1:0], p[0][5:0]};
        g.bytes[1] = {p[2][3:0], p[1][5:2]};
        g.bytes[2] = {p[3][5:0], p[2][5:4]};
        g.count    = CntW'(3);
      end
      FmtRaw7: begin
        g.bytes[0] = {p[1][0],   p[0][6:0]};
        g.bytes[1] = {p[2][1:0], p[1][6:1]};
        g.bytes[2] = {p[3][2:0], p[2][6:2]};
        g.bytes[3] = {p[4][3:0], p[3][6:3]};
        g.bytes[4] = {p[5][4:0], p[4][6:4]};
        g.bytes[5] = {p[6][5:0], p[5][6:5]};
        g.bytes[6] = {p[7][6:0], p[6][6]};
        g.count    = CntW'(7);
      end
      FmtRaw8: begin
        g.bytes[0] = p[0][7:0];
        g.count    = CntW'(1);
      end
      FmtRaw10: begin
        g.bytes[0] = p[0][9:2];
        g.bytes[1] = p[1][9:2];
        g.bytes[2] = p[2][9:2];
        g.bytes[3] = p[3][9:2];
        g.bytes[4] = {p[3][1:0], p[2][1:0], p[1][1:0], p[0][1:0]};
        g.count    = CntW'(5);
      end
      FmtRaw12: begin
        g.bytes[0] = p[0][11:4];
        g.bytes[1] = p[1][11:4];
        g.bytes[2] = {p[1][3:0], p[0][3:0]};
        g.count    = CntW'(3);
      end
      FmtRaw14: begin
        g.bytes[0] = p[0][13:6];
        g.bytes[1] = p[1][13:6];
        g.bytes[2] = p[2][13:6];
        g.bytes[3] = p[3][13:6];
        g.bytes[4] = {p[1][1:0], p[0][5:0]};
        g.bytes[5] = {p[2][3:0], p[1][5:2]};
        g.bytes[6] = {p[3][5:0], p[2][5:4]};
        g.count    = CntW'(7);
      end
      FmtRaw16: begin
        g.bytes[0] = p[0][15:8];
        g.bytes[1] = p[0][7:0];
        g.count    = CntW'(2);
      end
      FmtRaw20: begin
        g.bytes[0] = p[0][19:12];
        g.bytes[1] = p[0][11:4];
        g.bytes[2] = p[1][19:12];
        g.bytes[3] = p[1][11:4];
        g.bytes[4] = {p[1][3:0], p[0][3:0]};
        g.count    = CntW'(5);
      end
      FmtRgb888: begin
        g.bytes[0] = p[0][7:0];
        g.bytes[1] = p[0][15:8];
        g.bytes[2] = p[0][23:16];
        g.count    = CntW'(3);
      end
      default: begin
        g.count = '0;
      end
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

// File: sv/csi2rp_front.sv
// Front end: format register, pixel gathering into groups and packing of each finished group.
`default_nettype none

module csi2rp_front (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_valid_i,
  input  wire logic [csi2rp_pkg::FmtW-1:0] cfg_data_i,
  output logic                            cfg_ready_o,
  input  wire logic                       in_valid_i,
  input  wire csi2rp_pkg::pix_req_t       in_req_i,
  output logic                            in_ready_o,
  input  wire logic                       q_full_i,
  output logic                            q_push_o,
  output csi2rp_pkg::group_t              q_data_o
);

  logic [csi2rp_pkg::FmtW-1:0] fmt_q, fmt_d;
  logic [csi2rp_pkg::PosW-1:0] pos_q, pos_d;
  logic [csi2rp_pkg::StoreW-1:0] grp_q [csi2rp_pkg::GroupMax-2:0];

  logic                          accept;
  logic                          fmt_ok;
  logic                          completes;
  logic                          store;
  logic [csi2rp_pkg::LenW-1:0]   len;
  logic [csi2rp_pkg::PosW-1:0]   pos_eff;
  csi2rp_pkg::px_vec_t           px;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = ~q_full_i;
  assign accept      = in_valid_i & in_ready_o;

  assign fmt_ok = (fmt_q <= csi2rp_pkg::FmtW'(csi2rp_pkg::FmtRgb888));
  assign len    = csi2rp_pkg::group_len(fmt_q);

  // A stale position at or beyond the group size starts a fresh group.
  assign pos_eff   = ({1'b0, pos_q} >= len) ? '0 : pos_q;
  assign completes = fmt_ok & (({1'b0, pos_eff} + csi2rp_pkg::LenW'(1)) >= len);
  assign store     = accept & fmt_ok & ~completes;
  assign q_push_o  = accept & completes;

  always_comb begin
    px = '0;
    for (int i = 0; i < csi2rp_pkg::GroupMax - 1; i++) begin
      if (csi2rp_pkg::PosW'(i) < pos_eff) begin
        px[i] = {{(csi2rp_pkg::PixW - csi2rp_pkg::StoreW){1'b0}}, grp_q[i]};
      end
    end
    px[pos_eff] = in_req_i.pixel;
  end

  assign q_data_o = csi2rp_pkg::pack_group(fmt_q, px, in_req_i.line_end);

  always_comb begin
    fmt_d = fmt_q;
    pos_d = pos_q;
    if (cfg_valid_i && cfg_ready_o) begin
      fmt_d = cfg_data_i;
      pos_d = '0;
    end else if (accept) begin
      if (store && !in_req_i.line_end) begin
        pos_d = pos_eff + csi2rp_pkg::PosW'(1);
      end else begin
        pos_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= csi2rp_pkg::FmtRaw8;
      pos_q <= '0;
    end else begin
      fmt_q <= fmt_d;
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store) begin
      grp_q[pos_eff] <= in_req_i.pixel[csi2rp_pkg::StoreW-1:0];
    end
  end

endmodule

`default_nettype wire

// File: sv/csi2rp_fifo.sv
// Short queue of packed groups between the front end and the byte serializer.
`default_nettype none

module csi2rp_fifo #(
  parameter int unsigned Depth = csi2rp_pkg::QueueDepth
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire csi2rp_pkg::group_t  push_data_i,
  output logic                     full_o,
  input  wire logic                pop_i,
  output logic                     valid_o,
  output csi2rp_pkg::group_t       head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned NumW = $clog2(Depth + 1);

  csi2rp_pkg::group_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [NumW-1:0] num_q, num_d;

  assign full_o  = (num_q == NumW'(Depth));
  assign valid_o = (num_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    num_d    = num_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      num_d = num_q + NumW'(1);
    end else if (pop_i && !push_i) begin
      num_d = num_q - NumW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      num_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      num_q    <= num_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// File: sv/csi2rp_serializer.sv
// Back end: sends queued group bytes one per cycle via an output register unless stalled.
`default_nettype none

module csi2rp_serializer (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                q_valid_i,
  input  wire csi2rp_pkg::group_t  q_head_i,
  output logic                     q_pop_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output csi2rp_pkg::byte_rsp_t    out_rsp_o
);

  logic [csi2rp_pkg::CntW-1:0] idx_q, idx_d;
  logic                        out_valid_q, out_valid_d;
  csi2rp_pkg::byte_rsp_t       out_q;
  logic                        slot_free;
  logic                        emit;
  logic                        last;

  assign slot_free = ~out_valid_q | out_ready_i;
  assign emit      = slot_free & q_valid_i;
  assign last      = (idx_q == q_head_i.count - csi2rp_pkg::CntW'(1));
  assign q_pop_o   = emit & last;

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    if (emit) begin
      out_valid_d = 1'b1;
      idx_d       = last ? '0 : idx_q + csi2rp_pkg::CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q.out_byte  <= q_head_i.bytes[idx_q];
      out_q.run_last  <= last;
      out_q.line_done <= last & q_head_i.line_end;
    end
  end

endmodule

`default_nettype wire

// File: sv/csi2_raw_pixel_packer_unit.sv
// Top level of the CSI-2 RAW pixel packer: front end, group queue and byte serializer.
`default_nettype none

// Packs one pixel per request into CSI-2 payload bytes in the format held in the pixel_format
// register (RAW6 to RAW20 and RGB888); a partial group at line end is dropped and a format
// write drops any partial group. The front end takes one pixel per cycle while the group
// queue (QUEUE_DEPTH entries) has room; the serializer sends one byte per cycle while
// out_ready_i is high, so where a group has more bytes than pixels the serializer limits
// the sustained pixel rate. A completed group is written into the group queue and its bytes
// then leave through the one-byte output register.
module csi2_raw_pixel_packer_unit #(
  parameter int unsigned QUEUE_DEPTH = csi2rp_pkg::QueueDepth
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_valid_i,
  input  wire logic [csi2rp_pkg::FmtW-1:0] cfg_data_i,
  output logic                             cfg_ready_o,
  input  wire logic                        in_valid_i,
  input  wire csi2rp_pkg::pix_req_t        in_req_i,
  output logic                             in_ready_o,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output csi2rp_pkg::byte_rsp_t            out_rsp_o
);

  logic               q_full;
  logic               q_push;
  logic               q_pop;
  logic               q_valid;
  csi2rp_pkg::group_t q_wdata;
  csi2rp_pkg::group_t q_head;

  csi2rp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .in_valid_i  (in_valid_i),
    .in_req_i    (in_req_i),
    .in_ready_o  (in_ready_o),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_data_o    (q_wdata)
  );

  csi2rp_fifo #(
    .Depth (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  csi2rp_serializer u_serializer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

`default_nettype wire
